/* src/dqsl_pkg.sv */
// Shared types and constants of the deque and search-delete list block.
`default_nettype none
package dqsl_pkg;

  localparam int unsigned CAPACITY   = 32;
  localparam int unsigned AW         = $clog2(CAPACITY);
  localparam int unsigned CW         = $clog2(CAPACITY + 1);
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [5:0] NO_POS = 6'h3F;

  typedef enum logic [2:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_MOVE       = 3'd2,
    ACT_REMOVE     = 3'd3,
    ACT_REVERSE    = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_LIST_START,
    S_LIST_RD,
    S_LIST_OUT,
    S_LIST_EMPTY
  } state_e;

  // One classified command between front and back
  typedef struct packed {
    act_e        act;
    logic [31:0] id;
  } cmd_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage
`default_nettype wire

/* src/dqsl_front.sv */
// Front end: accepts input words, decodes the action and drops unused codes.
`default_nettype none
module dqsl_front (
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [31:0]         s_axis_tdata_i,  // patient_id[31:0]
  input  wire logic [2:0]          s_axis_tuser_i,  // action[2:0]
  input  wire dqsl_pkg::fifo_stat_t stat_i,
  output logic                     push_o,
  output dqsl_pkg::cmd_t           cmd_o
);

  logic known;

  // Classify the action code
  always_comb begin
    case (s_axis_tuser_i)
      dqsl_pkg::ACT_PUSH_BACK,
      dqsl_pkg::ACT_PUSH_FRONT,
      dqsl_pkg::ACT_MOVE,
      dqsl_pkg::ACT_REMOVE,
      dqsl_pkg::ACT_REVERSE: known = 1'b1;
      default:               known = 1'b0;
    endcase
  end

  // Accept while the queue has room; queue only known actions
  assign s_axis_tready_o = !stat_i.full;
  assign push_o          = s_axis_tvalid_i && !stat_i.full && known;
  assign cmd_o.act       = dqsl_pkg::act_e'(s_axis_tuser_i);
  assign cmd_o.id        = s_axis_tdata_i;

endmodule
`default_nettype wire

/* src/dqsl_cmd_fifo.sv */
// Short command queue between the front and back ends.
`default_nettype none
module dqsl_cmd_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire dqsl_pkg::cmd_t       cmd_i,
  input  wire logic                 pop_i,
  output dqsl_pkg::cmd_t            cmd_o,
  output dqsl_pkg::fifo_stat_t      stat_o
);

  dqsl_pkg::cmd_t                      mem_q [dqsl_pkg::FIFO_DEPTH];
  logic [dqsl_pkg::FIFO_AW-1:0]        wptr_q, wptr_d, rptr_q, rptr_d;
  logic [dqsl_pkg::FIFO_AW:0]          cnt_q, cnt_d;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == (dqsl_pkg::FIFO_AW+1)'(dqsl_pkg::FIFO_DEPTH));
  assign cmd_o        = mem_q[rptr_q];

  // Advance pointers and count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) wptr_d = wptr_q + 1'b1;
    if (pop_i)  rptr_d = rptr_q + 1'b1;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= cmd_i;
  end

endmodule
`default_nettype wire

/* src/dqsl_back.sv */
// Back end: runs each command on the deque and list memories and lists a store.
`default_nettype none
module dqsl_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dqsl_pkg::cmd_t       cmd_i,
  input  wire dqsl_pkg::fifo_stat_t stat_i,
  output logic                      pop_o,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic [47:0]               m_axis_tdata_o,  // entry_id[31:0], store_empty[32],
                                                     // found_position[38:33], status[40:39]
  output logic                      m_axis_tuser_o,  // store_select[0]
  output logic                      m_axis_tlast_o
);

  localparam int unsigned AW = dqsl_pkg::AW;
  localparam int unsigned CW = dqsl_pkg::CW;
  localparam logic [CW-1:0] CAP = CW'(dqsl_pkg::CAPACITY);

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(dqsl_pkg::CAPACITY)) s = s - (CW+1)'(dqsl_pkg::CAPACITY);
    return s[AW-1:0];
  endfunction

  dqsl_pkg::state_e  state_q, state_d;
  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     dcnt_q, dcnt_d, lcnt_q, lcnt_d, k_q, k_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic              hit_q, hit_d, sel_q, sel_d, rev_q, rev_d;
  dqsl_pkg::status_e status_q, status_d;
  logic [5:0]        fpos_q, fpos_d;
  logic [31:0]       id_q, id_d;

  logic [31:0] dmem [dqsl_pkg::CAPACITY];
  logic [31:0] lmem [dqsl_pkg::CAPACITY];
  logic [31:0] d_rdata_q, l_rdata_q;
  logic [AW-1:0] d_raddr, l_raddr, d_waddr, l_waddr;
  logic [31:0]   d_wdata, l_wdata;
  logic          d_we, l_we;

  logic          ov_q, out_load, match, k_last;
  logic [31:0]   oid_q;
  logic          oempty_q, osel_q, olast_q;
  logic [5:0]    opos_q;
  logic [1:0]    ost_q;
  logic [CW-1:0] cur_cnt, k_inc;

  assign cur_cnt  = sel_q ? lcnt_q : dcnt_q;
  assign k_inc    = k_q + 1'b1;
  assign k_last   = (k_inc == cur_cnt);
  assign match    = (l_rdata_q == id_q);
  assign out_load = !ov_q || m_axis_tready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dqsl_pkg::S_IDLE: begin
        if (!stat_i.empty) begin
          case (cmd_i.act)
            dqsl_pkg::ACT_MOVE:
              state_d = (dcnt_q != '0 && lcnt_q != CAP) ? dqsl_pkg::S_MOVE_RD
                                                         : dqsl_pkg::S_LIST_START;
            dqsl_pkg::ACT_REMOVE:
              state_d = (lcnt_q != '0) ? dqsl_pkg::S_SRCH_RD : dqsl_pkg::S_LIST_START;
            default: state_d = dqsl_pkg::S_LIST_START;
          endcase
        end
      end
      dqsl_pkg::S_MOVE_RD:  state_d = dqsl_pkg::S_MOVE_WR;
      dqsl_pkg::S_MOVE_WR:  state_d = dqsl_pkg::S_LIST_START;
      dqsl_pkg::S_SRCH_RD:  state_d = dqsl_pkg::S_SRCH_CMP;
      dqsl_pkg::S_SRCH_CMP: begin
        if (k_inc != lcnt_q)         state_d = dqsl_pkg::S_SRCH_RD;
        else if (hit_q || match)     state_d = dqsl_pkg::S_SHIFT_RD;
        else                         state_d = dqsl_pkg::S_LIST_START;
      end
      dqsl_pkg::S_SHIFT_RD:
        state_d = (k_inc >= lcnt_q) ? dqsl_pkg::S_LIST_START : dqsl_pkg::S_SHIFT_WR;
      dqsl_pkg::S_SHIFT_WR: state_d = dqsl_pkg::S_SHIFT_RD;
      dqsl_pkg::S_LIST_START:
        state_d = (cur_cnt == '0) ? dqsl_pkg::S_LIST_EMPTY : dqsl_pkg::S_LIST_RD;
      dqsl_pkg::S_LIST_RD:  state_d = dqsl_pkg::S_LIST_OUT;
      dqsl_pkg::S_LIST_OUT: begin
        if (out_load) state_d = k_last ? dqsl_pkg::S_IDLE : dqsl_pkg::S_LIST_RD;
      end
      dqsl_pkg::S_LIST_EMPTY: if (out_load) state_d = dqsl_pkg::S_IDLE;
      default: state_d = dqsl_pkg::S_IDLE;
    endcase
  end

  // Datapath registers
  always_comb begin
    head_d   = head_q;
    dcnt_d   = dcnt_q;
    lcnt_d   = lcnt_q;
    k_d      = k_q;
    pos_d    = pos_q;
    hit_d    = hit_q;
    sel_d    = sel_q;
    rev_d    = rev_q;
    status_d = status_q;
    fpos_d   = fpos_q;
    id_d     = id_q;
    case (state_q)
      dqsl_pkg::S_IDLE: begin
        if (!stat_i.empty) begin
          id_d     = cmd_i.id;
          k_d      = '0;
          hit_d    = 1'b0;
          rev_d    = 1'b0;
          fpos_d   = dqsl_pkg::NO_POS;
          status_d = dqsl_pkg::ST_OK;
          sel_d    = 1'b1;
          case (cmd_i.act)
            dqsl_pkg::ACT_PUSH_BACK, dqsl_pkg::ACT_PUSH_FRONT: begin
              sel_d = 1'b0;
              if (dcnt_q == CAP) status_d = dqsl_pkg::ST_FULL;
              else begin
                dcnt_d = dcnt_q + 1'b1;
                if (cmd_i.act == dqsl_pkg::ACT_PUSH_FRONT)
                  head_d = (head_q == '0) ? AW'(dqsl_pkg::CAPACITY - 1) : head_q - 1'b1;
              end
            end
            dqsl_pkg::ACT_MOVE: begin
              if (dcnt_q == '0)       status_d = dqsl_pkg::ST_EMPTY;
              else if (lcnt_q == CAP) status_d = dqsl_pkg::ST_FULL;
            end
            dqsl_pkg::ACT_REMOVE: if (lcnt_q == '0) status_d = dqsl_pkg::ST_NOMATCH;
            dqsl_pkg::ACT_REVERSE: rev_d = 1'b1;
            default: ;
          endcase
        end
      end
      dqsl_pkg::S_MOVE_WR: begin
        head_d = wrap_add(head_q, CW'(1));
        dcnt_d = dcnt_q - 1'b1;
        lcnt_d = lcnt_q + 1'b1;
      end
      dqsl_pkg::S_SRCH_CMP: begin
        if (match) begin
          hit_d = 1'b1;
          pos_d = k_q[AW-1:0];
        end
        k_d = k_inc;
        if (k_inc == lcnt_q) begin
          if (hit_q || match) begin
            k_d    = match ? k_q : CW'(pos_q);
            fpos_d = match ? 6'(k_q) : 6'(pos_q);
          end else begin
            status_d = dqsl_pkg::ST_NOMATCH;
            k_d      = '0;
          end
        end
      end
      dqsl_pkg::S_SHIFT_RD: begin
        if (k_inc >= lcnt_q) begin
          lcnt_d = lcnt_q - 1'b1;
          k_d    = '0;
        end
      end
      dqsl_pkg::S_SHIFT_WR: k_d = k_inc;
      dqsl_pkg::S_LIST_OUT: if (out_load) k_d = k_inc;
      default: ;
    endcase
  end

  // Memory ports and queue pop
  always_comb begin
    pop_o   = (state_q == dqsl_pkg::S_IDLE) && !stat_i.empty;
    d_raddr = head_q;
    l_raddr = k_q[AW-1:0];
    d_we    = 1'b0;
    d_waddr = wrap_add(head_q, dcnt_q);
    d_wdata = cmd_i.id;
    l_we    = 1'b0;
    l_waddr = lcnt_q[AW-1:0];
    l_wdata = d_rdata_q;
    case (state_q)
      dqsl_pkg::S_IDLE: begin
        if (!stat_i.empty && dcnt_q != CAP) begin
          if (cmd_i.act == dqsl_pkg::ACT_PUSH_BACK) d_we = 1'b1;
          if (cmd_i.act == dqsl_pkg::ACT_PUSH_FRONT) begin
            d_we    = 1'b1;
            d_waddr = (head_q == '0) ? AW'(dqsl_pkg::CAPACITY - 1) : head_q - 1'b1;
          end
        end
      end
      dqsl_pkg::S_MOVE_WR: l_we = 1'b1;
      dqsl_pkg::S_SHIFT_RD: l_raddr = k_inc[AW-1:0];
      dqsl_pkg::S_SHIFT_WR: begin
        l_we    = 1'b1;
        l_waddr = k_q[AW-1:0];
        l_wdata = l_rdata_q;
      end
      // Keep the listing address while the output word waits
      dqsl_pkg::S_LIST_RD, dqsl_pkg::S_LIST_OUT: begin
        d_raddr = wrap_add(head_q, k_q);
        l_raddr = rev_q ? AW'(lcnt_q - k_q - 1'b1) : k_q[AW-1:0];
      end
      default: ;
    endcase
  end

  // Hold the memories; read data registered
  always_ff @(posedge clk_i) begin
    if (d_we) dmem[d_waddr] <= d_wdata;
    if (l_we) lmem[l_waddr] <= l_wdata;
    d_rdata_q <= dmem[d_raddr];
    l_rdata_q <= lmem[l_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dqsl_pkg::S_IDLE;
      head_q  <= '0;
      dcnt_q  <= '0;
      lcnt_q  <= '0;
      k_q     <= '0;
      hit_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      dcnt_q  <= dcnt_d;
      lcnt_q  <= lcnt_d;
      k_q     <= k_d;
      hit_q   <= hit_d;
      if (out_load)
        ov_q <= (state_q == dqsl_pkg::S_LIST_OUT) || (state_q == dqsl_pkg::S_LIST_EMPTY);
    end
  end

  // Command fields and output word
  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    sel_q    <= sel_d;
    rev_q    <= rev_d;
    status_q <= status_d;
    fpos_q   <= fpos_d;
    id_q     <= id_d;
    if (out_load && (state_q == dqsl_pkg::S_LIST_OUT ||
                     state_q == dqsl_pkg::S_LIST_EMPTY)) begin
      oempty_q <= (state_q == dqsl_pkg::S_LIST_EMPTY);
      oid_q    <= (state_q == dqsl_pkg::S_LIST_EMPTY) ? 32'd0 :
                  (sel_q ? l_rdata_q : d_rdata_q);
      olast_q  <= (state_q == dqsl_pkg::S_LIST_EMPTY) || k_last;
      osel_q   <= sel_q;
      opos_q   <= fpos_q;
      ost_q    <= status_q;
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {7'd0, ost_q, opos_q, oempty_q, oid_q};
  assign m_axis_tuser_o  = osel_q;
  assign m_axis_tlast_o  = olast_q;

endmodule
`default_nettype wire

/* src/deque_feeding_search_delete_list.sv */
// Top level: deque and search-delete list with a queued command front end.
// A push lists the deque; a move first shifts its front entry to the list; a removal
// searches every list entry, then shifts later entries down; listing reads and then outputs
// each result (one word if empty). One command at a time in the back end, each store memory
// having a single read port; no new command is taken until the listing is done.
// Reset: both stores empty, queue empty, no result pending; no clearing pass.
`default_nettype none
module deque_feeding_search_delete_list (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // patient_id[31:0]
  input  wire logic [2:0]  s_axis_tuser_i,   // action[2:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,   // entry_id[31:0], store_empty[32],
                                             // found_position[38:33], status[40:39]
  output logic             m_axis_tuser_o,   // store_select[0]
  output logic             m_axis_tlast_o
);

  dqsl_pkg::fifo_stat_t stat;
  dqsl_pkg::cmd_t       front_cmd, back_cmd;
  logic                 push, pop;

  dqsl_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .stat_i          (stat),
    .push_o          (push),
    .cmd_o           (front_cmd)
  );

  dqsl_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (pop),
    .cmd_o  (back_cmd),
    .stat_o (stat)
  );

  dqsl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (back_cmd),
    .stat_i          (stat),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
`default_nettype wire
